### design/grouped_free_block_allocator_unit_macros.svh
// assertion macros for the grouped free block allocator
// used by the sequencer, no other dependencies
`ifndef GROUPED_FREE_BLOCK_ALLOCATOR_UNIT_MACROS_SVH
`define GROUPED_FREE_BLOCK_ALLOCATOR_UNIT_MACROS_SVH

// same-cycle implication under synchronous active-low reset
`define GFBA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under synchronous active-low reset
`define GFBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/gfba_pkg.sv
`timescale 1ns / 1ps
// constants, codes and shared structs of the grouped free block allocator
// no dependencies
package gfba_pkg;

    localparam int FREE_STACK_DEPTH = 16;
    localparam int BLOCK_COUNT      = 512;
    localparam int RESERVED_BLOCKS  = 3;

    localparam int WORD_W  = 16;
    localparam int IDX_W   = $clog2(FREE_STACK_DEPTH);
    localparam int TOP_W   = $clog2(FREE_STACK_DEPTH + 1);
    localparam int LEN_W   = TOP_W;
    localparam int BLK_W   = $clog2(BLOCK_COUNT);
    localparam int WADDR_W = $clog2(BLOCK_COUNT * FREE_STACK_DEPTH);

    localparam logic [WORD_W:0] BLOCK_LIMIT = (WORD_W + 1)'(BLOCK_COUNT);

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_RESERVED = 2'd2;
    localparam logic [1:0] ST_RANGE    = 2'd3;

    typedef struct packed {
        logic                word_we;
        logic                word_re;
        logic [WADDR_W-1:0]  word_addr;
        logic [WORD_W-1:0]   word_wdata;
        logic                len_we;
        logic                len_re;
        logic [BLK_W-1:0]    len_addr;
        logic [LEN_W-1:0]    len_wdata;
    } t_store_req;

    typedef struct packed {
        logic [WORD_W-1:0] word_rdata;
        logic [LEN_W-1:0]  len_rdata;
        logic              busy;
    } t_store_rsp;

    typedef struct packed {
        logic              valid;
        logic [WORD_W-1:0] blk;
        logic [1:0]        status;
    } t_result;

endpackage

### design/gfba_if.sv
`timescale 1ns / 1ps
// valid/ready channel interfaces for command items and result items
// depends on nothing
interface gfba_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [15:0] block_number;

    modport source (output valid, output command, output block_number, input ready);
    modport sink   (input valid, input command, input block_number, output ready);
endinterface

interface gfba_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] allocated_block;
    logic [1:0]  status;

    modport source (output valid, output allocated_block, output status, input ready);
    modport sink   (input valid, input allocated_block, input status, output ready);
endinterface

### design/gfba_store.sv
`timescale 1ns / 1ps
// saved group words and group lengths, with the length clearing pass after reset
// depends on gfba_pkg
module gfba_store (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  gfba_pkg::t_store_req  i_req,
    output gfba_pkg::t_store_rsp  o_rsp
);

    logic [gfba_pkg::WORD_W-1:0] r_words [gfba_pkg::BLOCK_COUNT * gfba_pkg::FREE_STACK_DEPTH];
    logic [gfba_pkg::LEN_W-1:0]  r_lens  [gfba_pkg::BLOCK_COUNT];

    logic [gfba_pkg::WORD_W-1:0] r_word_rdata;
    logic [gfba_pkg::LEN_W-1:0]  r_len_rdata;
    logic                        r_clr_busy;
    logic                        n_clr_busy;
    logic [gfba_pkg::BLK_W-1:0]  r_clr_addr;
    logic [gfba_pkg::BLK_W-1:0]  n_clr_addr;

    logic                        len_we;
    logic [gfba_pkg::BLK_W-1:0]  len_waddr;
    logic [gfba_pkg::LEN_W-1:0]  len_wdata;

    always_comb begin
        n_clr_busy = r_clr_busy;
        n_clr_addr = r_clr_addr;
        if (r_clr_busy) begin
            if (r_clr_addr == gfba_pkg::BLK_W'(gfba_pkg::BLOCK_COUNT - 1)) begin
                n_clr_busy = 1'b0;
            end else begin
                n_clr_addr = r_clr_addr + gfba_pkg::BLK_W'(1);
            end
        end
    end

    assign len_we    = r_clr_busy | i_req.len_we;
    assign len_waddr = r_clr_busy ? r_clr_addr : i_req.len_addr;
    assign len_wdata = r_clr_busy ? '0 : i_req.len_wdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            r_clr_busy <= n_clr_busy;
            r_clr_addr <= n_clr_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.word_we) begin
            r_words[i_req.word_addr] <= i_req.word_wdata;
        end
        if (i_req.word_re) begin
            r_word_rdata <= r_words[i_req.word_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (len_we) begin
            r_lens[len_waddr] <= len_wdata;
        end
        if (i_req.len_re) begin
            r_len_rdata <= r_lens[i_req.len_addr];
        end
    end

    assign o_rsp.word_rdata = r_word_rdata;
    assign o_rsp.len_rdata  = r_len_rdata;
    assign o_rsp.busy       = r_clr_busy;

endmodule

### design/gfba_seq.sv
`timescale 1ns / 1ps
// sequencer: free stack, free count and the step-by-step group save and reload
// depends on gfba_pkg and the assertion macro header
`include "grouped_free_block_allocator_unit_macros.svh"

module gfba_seq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic                        i_cmd,
    input  logic [gfba_pkg::WORD_W-1:0] i_blk,
    output logic                        o_idle,
    output gfba_pkg::t_result           o_res,
    input  logic                        i_res_ready,
    output gfba_pkg::t_store_req        o_req,
    input  gfba_pkg::t_store_rsp        i_rsp
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_LEN  = 3'd2;
    localparam logic [2:0] S_LOAD = 3'd3;
    localparam logic [2:0] S_SAVE = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    localparam int DEPTH = gfba_pkg::FREE_STACK_DEPTH;
    localparam int IDX_W = gfba_pkg::IDX_W;
    localparam int TOP_W = gfba_pkg::TOP_W;
    localparam int WW    = gfba_pkg::WORD_W;
    localparam int AW    = gfba_pkg::WADDR_W;
    localparam int BW    = gfba_pkg::BLK_W;

    logic [2:0]                  r_state, n_state;
    logic                        r_cmd, n_cmd;
    logic [WW-1:0]               r_blk, n_blk;
    logic [TOP_W-1:0]            r_top, n_top;
    logic [WW-1:0]               r_count, n_count;
    logic [IDX_W-1:0]            r_idx, n_idx;
    logic [gfba_pkg::LEN_W-1:0]  r_len, n_len;
    logic [AW-1:0]               r_base, n_base;
    logic [WW-1:0]               r_res_blk, n_res_blk;
    logic [1:0]                  r_res_status, n_res_status;
    logic [WW-1:0]               r_stack [DEPTH];

    logic [IDX_W-1:0]            rd_idx;
    logic [WW-1:0]               stk_val;
    logic                        stk_we;
    logic [IDX_W-1:0]            stk_widx;
    logic [WW-1:0]               stk_wdata;
    logic                        stk_bad;
    logic                        blk_reserved;
    logic                        blk_range;
    logic [WW-1:0]               count_inc;
    logic [gfba_pkg::LEN_W-1:0]  len_rd;

    assign rd_idx  = (r_state == S_SAVE) ? (IDX_W'(DEPTH - 1) - r_idx) : r_top[IDX_W-1:0];
    assign stk_val = r_stack[rd_idx];
    assign stk_bad = (stk_val < WW'(gfba_pkg::RESERVED_BLOCKS))
                   || ({1'b0, stk_val} >= gfba_pkg::BLOCK_LIMIT);
    assign blk_reserved = r_blk < WW'(gfba_pkg::RESERVED_BLOCKS);
    assign blk_range    = {1'b0, r_blk} >= gfba_pkg::BLOCK_LIMIT;
    assign count_inc    = (r_count == '1) ? r_count : (r_count + WW'(1));
    assign len_rd       = i_rsp.len_rdata;

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_blk        = r_blk;
        n_top        = r_top;
        n_count      = r_count;
        n_idx        = r_idx;
        n_len        = r_len;
        n_base       = r_base;
        n_res_blk    = r_res_blk;
        n_res_status = r_res_status;
        stk_we       = 1'b0;
        stk_widx     = '0;
        stk_wdata    = r_blk;
        o_req        = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_cmd   = i_cmd;
                    n_blk   = i_blk;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state      = S_DONE;
                n_res_blk    = '0;
                n_res_status = gfba_pkg::ST_OK;
                if (r_cmd == gfba_pkg::CMD_ALLOC) begin
                    priority if (r_count == '0) begin
                        n_res_status = gfba_pkg::ST_FULL;
                    end else if (r_top >= TOP_W'(DEPTH) || stk_bad) begin
                        n_count      = '0;
                        n_res_status = gfba_pkg::ST_FULL;
                    end else if (r_top == TOP_W'(DEPTH - 1)) begin
                        n_blk          = stk_val;
                        n_base         = AW'(AW'(stk_val[BW-1:0]) * AW'(DEPTH));
                        o_req.len_re   = 1'b1;
                        o_req.len_addr = stk_val[BW-1:0];
                        n_state        = S_LEN;
                    end else begin
                        n_top     = r_top + TOP_W'(1);
                        n_count   = r_count - WW'(1);
                        n_res_blk = stk_val;
                    end
                end else begin
                    priority if (blk_reserved) begin
                        n_res_status = gfba_pkg::ST_RESERVED;
                    end else if (blk_range) begin
                        n_res_status = gfba_pkg::ST_RANGE;
                    end else if (r_top == '0) begin
                        n_base  = AW'(AW'(r_blk[BW-1:0]) * AW'(DEPTH));
                        n_idx   = '0;
                        n_state = S_SAVE;
                    end else if (r_top >= TOP_W'(DEPTH)) begin
                        o_req.len_we    = 1'b1;
                        o_req.len_addr  = r_blk[BW-1:0];
                        o_req.len_wdata = '0;
                        n_top           = TOP_W'(DEPTH - 1);
                        stk_we          = 1'b1;
                        stk_widx        = IDX_W'(DEPTH - 1);
                        n_count         = count_inc;
                    end else begin
                        n_top    = r_top - TOP_W'(1);
                        stk_we   = 1'b1;
                        stk_widx = IDX_W'(r_top - TOP_W'(1));
                        n_count  = count_inc;
                    end
                end
            end
            S_LEN: begin
                if (len_rd == '0 || len_rd > gfba_pkg::LEN_W'(DEPTH)) begin
                    n_count      = '0;
                    n_top        = TOP_W'(DEPTH);
                    n_res_blk    = r_blk;
                    n_res_status = gfba_pkg::ST_OK;
                    n_state      = S_DONE;
                end else begin
                    n_len           = len_rd;
                    n_idx           = '0;
                    o_req.word_re   = 1'b1;
                    o_req.word_addr = r_base;
                    n_state         = S_LOAD;
                end
            end
            S_LOAD: begin
                stk_we    = 1'b1;
                stk_widx  = IDX_W'(DEPTH - 1) - r_idx;
                stk_wdata = i_rsp.word_rdata;
                if (TOP_W'(r_idx) == r_len - TOP_W'(1)) begin
                    n_top        = TOP_W'(DEPTH) - r_len;
                    n_count      = r_count - WW'(1);
                    n_res_blk    = r_blk;
                    n_res_status = gfba_pkg::ST_OK;
                    n_state      = S_DONE;
                end else begin
                    n_idx           = r_idx + IDX_W'(1);
                    o_req.word_re   = 1'b1;
                    o_req.word_addr = r_base + AW'(n_idx);
                end
            end
            S_SAVE: begin
                o_req.word_we    = 1'b1;
                o_req.word_addr  = r_base + AW'(r_idx);
                o_req.word_wdata = stk_val;
                if (r_idx == IDX_W'(DEPTH - 1)) begin
                    o_req.len_we    = 1'b1;
                    o_req.len_addr  = r_blk[BW-1:0];
                    o_req.len_wdata = gfba_pkg::LEN_W'(DEPTH);
                    n_top           = TOP_W'(DEPTH - 1);
                    stk_we          = 1'b1;
                    stk_widx        = IDX_W'(DEPTH - 1);
                    n_count         = count_inc;
                    n_res_blk       = '0;
                    n_res_status    = gfba_pkg::ST_OK;
                    n_state         = S_DONE;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_top   <= TOP_W'(DEPTH);
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_top   <= n_top;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_blk        <= n_blk;
        r_idx        <= n_idx;
        r_len        <= n_len;
        r_base       <= n_base;
        r_res_blk    <= n_res_blk;
        r_res_status <= n_res_status;
        if (stk_we) begin
            r_stack[stk_widx] <= stk_wdata;
        end
    end

    assign o_idle       = (r_state == S_IDLE);
    assign o_res.valid  = (r_state == S_DONE);
    assign o_res.blk    = r_res_blk;
    assign o_res.status = r_res_status;

    `GFBA_ASSERT_NOW(a_top_range, i_clk, i_rst_n, 1'b1, r_top <= TOP_W'(DEPTH), "stack top past empty mark")
    `GFBA_ASSERT_NOW(a_save_full, i_clk, i_rst_n, r_state == S_SAVE, r_top == '0, "group save with stack not full")
    `GFBA_ASSERT_NOW(a_load_len, i_clk, i_rst_n, r_state == S_LOAD, (r_len != '0) && (r_len <= gfba_pkg::LEN_W'(DEPTH)), "reload with bad group length")
    `GFBA_ASSERT_NOW(a_fail_zero, i_clk, i_rst_n, (r_state == S_DONE) && (r_res_status != gfba_pkg::ST_OK), r_res_blk == '0, "failed item carries a block number")
    `GFBA_ASSERT_NEXT(a_count_zero, i_clk, i_rst_n, (r_state == S_EXEC) && (r_cmd == gfba_pkg::CMD_ALLOC) && (n_res_status == gfba_pkg::ST_FULL), r_count == '0, "full report left a nonzero count")

endmodule

### design/grouped_free_block_allocator_unit.sv
`timescale 1ns / 1ps
// a free that saves a group writes the full stack to the store, one stack word per cycle;
// an allocate that pops the leader reloads that block's saved group, unless it is a chain end.
// a new item is accepted only once the sequencer has handed the previous result on.
// reset: synchronous; a clearing pass over all BLOCK_COUNT group lengths zeroes them,
// and no item is accepted until it ends
module grouped_free_block_allocator_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    gfba_in_if.sink       i_in,
    gfba_out_if.source    o_out
);

    gfba_pkg::t_store_req store_req;
    gfba_pkg::t_store_rsp store_rsp;
    gfba_pkg::t_result    res;
    logic                 seq_idle;
    logic                 res_ready;
    logic                 start;

    logic                 r_out_valid;
    logic [15:0]          r_out_blk;
    logic [1:0]           r_out_status;

    assign i_in.ready = seq_idle && !store_rsp.busy;
    assign start      = i_in.valid && i_in.ready;
    assign res_ready  = !r_out_valid || o_out.ready;

    gfba_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_cmd       (i_in.command),
        .i_blk       (i_in.block_number),
        .o_idle      (seq_idle),
        .o_res       (res),
        .i_res_ready (res_ready),
        .o_req       (store_req),
        .i_rsp       (store_rsp)
    );

    gfba_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (store_req),
        .o_rsp   (store_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res.valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.valid && res_ready) begin
            r_out_blk    <= res.blk;
            r_out_status <= res.status;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.allocated_block = r_out_blk;
    assign o_out.status          = r_out_status;

endmodule
